>>> src/plx_pkg.sv
// Shared types, character codes, token kinds and the byte classifier of the scanner.
package plx_pkg;

  // Token kinds as they appear on the result channel.
  localparam logic [4:0] K_LPAREN    = 5'd0;
  localparam logic [4:0] K_RPAREN    = 5'd1;
  localparam logic [4:0] K_LBRACE    = 5'd2;
  localparam logic [4:0] K_RBRACE    = 5'd3;
  localparam logic [4:0] K_SEMI      = 5'd4;
  localparam logic [4:0] K_COMMA     = 5'd5;
  localparam logic [4:0] K_DOT       = 5'd6;
  localparam logic [4:0] K_MINUS     = 5'd7;
  localparam logic [4:0] K_PLUS      = 5'd8;
  localparam logic [4:0] K_SLASH     = 5'd9;
  localparam logic [4:0] K_STAR      = 5'd10;
  localparam logic [4:0] K_BANG      = 5'd11;
  localparam logic [4:0] K_BANG_EQ   = 5'd12;
  localparam logic [4:0] K_EQUAL     = 5'd13;
  localparam logic [4:0] K_EQUAL_EQ  = 5'd14;
  localparam logic [4:0] K_LESS      = 5'd15;
  localparam logic [4:0] K_LESS_EQ   = 5'd16;
  localparam logic [4:0] K_GREATER   = 5'd17;
  localparam logic [4:0] K_GREATER_EQ = 5'd18;
  localparam logic [4:0] K_ERROR     = 5'd19;
  localparam logic [4:0] K_EOF       = 5'd20;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  // Depth of the record queue between front and back.
  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_SLASH   = 3'd1,
    M_COMMENT = 3'd2,
    M_BANG    = 3'd3,
    M_EQUAL   = 3'd4,
    M_LESS    = 3'd5,
    M_GREATER = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    BC_SKIP,
    BC_NEWLINE,
    BC_LEAD,
    BC_SINGLE,
    BC_ERROR
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t  cls;
    logic [4:0] kind;
    mode_t      lead;
  } byte_info_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [1:0]  len;
    logic [15:0] line;
  } tok_t;

  // All tokens caused by one source byte; the second slot is used only when two is set.
  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } rec_t;

  // Classifies one byte as seen in normal mode.
  function automatic byte_info_t classify(input logic [7:0] b);
    byte_info_t info;
    info.cls  = BC_ERROR;
    info.kind = K_ERROR;
    info.lead = M_NORMAL;
    unique case (b) inside
      CH_SPACE, CH_TAB, CH_CR: info.cls = BC_SKIP;
      CH_NL:      info.cls = BC_NEWLINE;
      CH_SLASH:   begin info.cls = BC_LEAD; info.lead = M_SLASH;   end
      CH_BANG:    begin info.cls = BC_LEAD; info.lead = M_BANG;    end
      CH_EQ:      begin info.cls = BC_LEAD; info.lead = M_EQUAL;   end
      CH_LESS:    begin info.cls = BC_LEAD; info.lead = M_LESS;    end
      CH_GREATER: begin info.cls = BC_LEAD; info.lead = M_GREATER; end
      CH_LPAREN:  begin info.cls = BC_SINGLE; info.kind = K_LPAREN; end
      CH_RPAREN:  begin info.cls = BC_SINGLE; info.kind = K_RPAREN; end
      CH_LBRACE:  begin info.cls = BC_SINGLE; info.kind = K_LBRACE; end
      CH_RBRACE:  begin info.cls = BC_SINGLE; info.kind = K_RBRACE; end
      CH_SEMI:    begin info.cls = BC_SINGLE; info.kind = K_SEMI;   end
      CH_COMMA:   begin info.cls = BC_SINGLE; info.kind = K_COMMA;  end
      CH_DOT:     begin info.cls = BC_SINGLE; info.kind = K_DOT;    end
      CH_MINUS:   begin info.cls = BC_SINGLE; info.kind = K_MINUS;  end
      CH_PLUS:    begin info.cls = BC_SINGLE; info.kind = K_PLUS;   end
      CH_STAR:    begin info.cls = BC_SINGLE; info.kind = K_STAR;   end
      default:    info.cls = BC_ERROR;
    endcase
    return info;
  endfunction

endpackage

>>> src/plx_front.sv
// Front end of the scanner: takes source bytes, tracks scan state and builds token records.
module plx_front #(
  parameter longint unsigned MAX_SOURCE_BYTES = 65536,
  parameter longint unsigned MAX_LINES        = 65535
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  logic [7:0]    source_byte,
  output logic          rec_push,
  output plx_pkg::rec_t rec_data,
  input  logic          rec_full
);
  import plx_pkg::*;

  localparam int POS_W  = $clog2(MAX_SOURCE_BYTES);
  localparam int LINE_W = $clog2(MAX_LINES + 1);
  localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(MAX_SOURCE_BYTES - 1);
  localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_LINES);

  mode_t             mode_r, mode_nxt;
  logic [POS_W-1:0]  pstart_r, pstart_nxt;
  logic [LINE_W-1:0] pline_r, pline_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  byte_info_t info;
  logic       accept;
  logic       h_valid, n_valid, e_valid, norm_en;
  tok_t       h_tok, n_tok, e_tok;

  assign byte_ready = !rec_full;
  assign accept     = byte_valid && byte_ready;
  assign info       = classify(source_byte);

  always_comb begin
    mode_nxt   = mode_r;
    pstart_nxt = pstart_r;
    pline_nxt  = pline_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    h_valid    = 1'b0;
    n_valid    = 1'b0;
    e_valid    = 1'b0;
    norm_en    = 1'b0;
    h_tok.kind  = K_SLASH;
    h_tok.start = 16'(pstart_r);
    h_tok.len   = 2'd1;
    h_tok.line  = 16'(pline_r);

    // Resolve a held lead character against the new byte.
    unique case (mode_r)
      M_COMMENT: begin
        norm_en = (source_byte == CH_NL);
      end
      M_SLASH: begin
        if (source_byte == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else begin
          h_valid  = 1'b1;
          mode_nxt = M_NORMAL;
          norm_en  = (source_byte != CH_NUL);
        end
      end
      M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
        h_valid  = 1'b1;
        mode_nxt = M_NORMAL;
        unique case (mode_r)
          M_BANG:  h_tok.kind = K_BANG;
          M_EQUAL: h_tok.kind = K_EQUAL;
          M_LESS:  h_tok.kind = K_LESS;
          default: h_tok.kind = K_GREATER;
        endcase
        if (source_byte == CH_EQ) begin
          h_tok.kind = h_tok.kind + 5'd1;
          h_tok.len  = 2'd2;
        end else begin
          norm_en = (source_byte != CH_NUL);
        end
      end
      default: begin
        norm_en = (source_byte != CH_NUL);
      end
    endcase

    // The byte itself, handled as in normal mode.
    n_tok.kind  = info.kind;
    n_tok.start = 16'(pos_r);
    n_tok.len   = 2'd1;
    n_tok.line  = 16'(line_r);
    if (norm_en) begin
      mode_nxt = M_NORMAL;
      unique case (info.cls)
        BC_SKIP: ;
        BC_NEWLINE: begin
          if (line_r != LINE_MAX) begin
            line_nxt = line_r + LINE_W'(1);
          end
        end
        BC_LEAD: begin
          mode_nxt   = info.lead;
          pstart_nxt = pos_r;
          pline_nxt  = line_r;
        end
        default: n_valid = 1'b1;
      endcase
    end

    e_tok.kind  = K_EOF;
    e_tok.start = 16'(pos_r);
    e_tok.len   = 2'd0;
    e_tok.line  = 16'(line_r);
    if (source_byte == CH_NUL) begin
      e_valid    = 1'b1;
      mode_nxt   = M_NORMAL;
      pstart_nxt = '0;
      pline_nxt  = LINE_W'(1);
      pos_nxt    = '0;
      line_nxt   = LINE_W'(1);
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Held token first, then the byte's own token or the end-of-file token.
  assign rec_data.t0  = h_valid ? h_tok : (n_valid ? n_tok : e_tok);
  assign rec_data.t1  = n_valid ? n_tok : e_tok;
  assign rec_data.two = h_valid && (n_valid || e_valid);
  assign rec_push     = accept && (h_valid || n_valid || e_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_NORMAL;
      pstart_r <= '0;
      pline_r  <= LINE_W'(1);
      pos_r    <= '0;
      line_r   <= LINE_W'(1);
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pstart_r <= pstart_nxt;
      pline_r  <= pline_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

>>> src/plx_queue.sv
// Short record queue that lets the front and back of the scanner stall independently.
module plx_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  plx_pkg::rec_t                  push_data,
  output logic                           full,
  input  logic                           pop,
  output logic                           head_valid,
  output plx_pkg::rec_t                  head_data,
  output logic [$clog2(plx_pkg::QDEPTH+1)-1:0] count
);
  import plx_pkg::*;

  localparam int AW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  rec_t          mem [QDEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == CW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem[rd_ptr_r];
  assign count      = count_r;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> src/plx_back.sv
// Back end of the scanner: splits records into tokens and drives the registered result channel.
module plx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  plx_pkg::rec_t head_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [4:0]    token_kind,
  output logic [15:0]   start_offset,
  output logic [1:0]    lexeme_length,
  output logic [15:0]   line_number,
  output logic          last_of_run
);
  import plx_pkg::*;

  logic valid_r;
  logic sel_r, sel_nxt;
  tok_t tok_r;
  logic last_r;
  logic load;
  logic first_of_two;

  assign load         = head_valid && (!valid_r || out_ready);
  assign first_of_two = head_data.two && !sel_r;
  assign pop          = load && !first_of_two;
  assign sel_nxt      = load ? first_of_two : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= sel_r ? head_data.t1 : head_data.t0;
      last_r <= !first_of_two;
    end
  end

  assign out_valid     = valid_r;
  assign token_kind    = tok_r.kind;
  assign start_offset  = tok_r.start;
  assign lexeme_length = tok_r.len;
  assign line_number   = tok_r.line;
  assign last_of_run   = last_r;

endmodule

>>> src/punctuation_lexer_unit.sv
// Top level of the punctuation and comment scanner.
// The scanner takes one source byte per clock cycle on the in_ channel, with a zero byte marking
// the end of the source, and delivers tokens on the out_ channel. Whitespace is skipped, a newline
// advances the line count, and a double slash starts a comment that runs to the next newline.
// The lead characters ! = < > and / are held until the next byte shows whether they pair with a
// second character, so a single request can cause zero, one or two tokens; out_last_of_run marks
// the final token caused by a request. A zero byte yields an end-of-file token of length zero and
// returns the scanner to its reset state. Input is accepted at one byte per cycle for as long as
// the record queue has room; the two tokens of a request leave the output port one after the
// other, and the sustained output rate is one token per cycle while out_ready is high. With an
// empty queue and a free output register, the front end writes the request's tokens into a
// four-record queue at the edge that accepts the request, and the back end then moves the first
// of them into the output register. The byte offset saturates at MAX_SOURCE_BYTES - 1 and the
// line count at MAX_LINES; both are reported through their low 16 bits.
module punctuation_lexer_unit #(
  parameter longint unsigned MAX_SOURCE_BYTES = 65536,
  parameter longint unsigned MAX_LINES        = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_start_offset,
  output logic [1:0]  out_lexeme_length,
  output logic [15:0] out_line_number,
  output logic        out_last_of_run
);
  import plx_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  // Records from the front end into the queue.
  logic          rec_push;
  rec_t          rec_data;
  logic          rec_full;

  // Head of the queue toward the back end.
  logic          head_valid;
  rec_t          head_data;
  logic          head_pop;
  logic [CW-1:0] q_count;

  // The front end classifies each byte and resolves held lead characters.
  plx_front #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
    .MAX_LINES       (MAX_LINES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_valid),
    .byte_ready (in_ready),
    .source_byte(in_source_byte),
    .rec_push   (rec_push),
    .rec_data   (rec_data),
    .rec_full   (rec_full)
  );

  // The queue decouples byte intake from token delivery.
  plx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_data),
    .full      (rec_full),
    .pop       (head_pop),
    .head_valid(head_valid),
    .head_data (head_data),
    .count     (q_count)
  );

  // The back end issues one token per cycle into the output register while records wait and out_ready is high.
  plx_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .pop          (head_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (out_token_kind),
    .start_offset (out_start_offset),
    .lexeme_length(out_lexeme_length),
    .line_number  (out_line_number),
    .last_of_run  (out_last_of_run)
  );

  // Only the end-of-file token has zero length.
  a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_token_kind == K_EOF) == (out_lexeme_length == 2'd0)))
    else $error("token length does not match end-of-file kind");

  // Nothing follows the end-of-file token within a request.
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == K_EOF) |-> out_last_of_run)
    else $error("end-of-file token not marked last");

  // The front end never pushes into a full queue, since it stalls input when full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> !rec_full)
    else $error("record pushed into full queue");

  // Line numbers start at one and never wrap to zero.
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && q_count <= CW'(QDEPTH)) |-> (out_line_number != 16'd0))
    else $error("token reported on line zero");

endmodule
